>>> hw/rtl/ssp_pkg.sv
`default_nettype none
package ssp_pkg;

  localparam logic [1:0] REG_START_PERIOD = 2'd0;
  localparam logic [1:0] REG_MIN_PERIOD   = 2'd1;
  localparam logic [1:0] REG_RAMP_STEP    = 2'd2;

  localparam logic [15:0] START_PERIOD_RESET = 16'd25500;
  localparam logic [15:0] MIN_PERIOD_RESET   = 16'd2550;
  localparam logic [7:0]  RAMP_STEP_RESET    = 8'd2;

  localparam logic [16:0] RECIP10  = 17'd52429;
  localparam int          SHIFT10  = 19;
  localparam logic [16:0] RECIP100 = 17'd83887;
  localparam int          SHIFT100 = 23;
  localparam logic [16:0] CEIL_BIAS100 = 17'd99;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SINE_SCALE  = 64'd126;

  typedef struct packed {
    logic tick_elapsed;
  } ssp_in_t;

  typedef struct packed {
    logic [7:0]  duty_a;
    logic [7:0]  duty_b;
    logic [7:0]  duty_c;
    logic [7:0]  sine_position;
    logic [12:0] wait_ticks;
    logic        still_ramping;
  } ssp_out_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } ssp_cfg_t;

  typedef struct packed {
    logic [15:0] start_period;
    logic [15:0] min_period;
    logic [7:0]  ramp_step;
  } ssp_regs_t;

  typedef struct packed {
    logic [15:0] period;
    logic        ramping;
    logic [12:0] wait_ticks;
  } ssp_upd_t;

  function automatic logic [7:0] sine_entry(input longint unsigned th_in, input int offset);
    longint unsigned th;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned negsum;
    longint unsigned s;
    longint unsigned lvl;
    longint unsigned v;
    bit neg;
    th = th_in;
    neg = 1'b0;
    if (th >= PI_Q30) begin
      th = th - PI_Q30;
      neg = 1'b1;
    end
    if (th > HALF_PI_Q30) begin
      th = PI_Q30 - th;
    end
    term = th;
    pos = th;
    negsum = 64'd0;
    for (int n = 1; n <= 8; n++) begin
      term = (term * th) >> 30;
      term = (term * th) >> 30;
      case (n)
        1: term = term / 6;
        2: term = term / 20;
        3: term = term / 42;
        4: term = term / 72;
        5: term = term / 110;
        6: term = term / 156;
        7: term = term / 210;
        default: term = term / 272;
      endcase
      if (n % 2 == 1) begin
        negsum = negsum + term;
      end else begin
        pos = pos + term;
      end
    end
    s = (pos > negsum) ? pos - negsum : 64'd0;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    lvl = neg ? (Q30_ONE - s) : (Q30_ONE + s);
    v = 64'(offset) + ((lvl * SINE_SCALE) >> 30);
    return (v > 64'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [7:0] sat_sub(input logic [7:0] v, input logic [9:0] cut);
    return ({2'b00, v} > cut) ? 8'({2'b00, v} - cut) : 8'd0;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ssp_stream_if.sv
`default_nettype none
interface ssp_stream_if #(parameter type payload_t = logic [0:0]) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ssp_step.sv
`default_nettype none
module ssp_step #(
  parameter int TABLE_POINTS = 256,
  parameter int IDX_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              tick_valid,
  input  wire ssp_pkg::ssp_regs_t regs,
  input  wire logic              start_load,
  input  wire logic [15:0]       start_value,
  output logic                   upd_valid_r,
  output logic [IDX_W-1:0]       pos_r,
  output ssp_pkg::ssp_upd_t      upd_r
);
  import ssp_pkg::*;

  logic [IDX_W-1:0] phase_r;
  logic [IDX_W-1:0] phase_nxt;
  logic [15:0]      period_r;
  logic [15:0]      period_nxt;
  logic [12:0]      countdown_r;
  logic [12:0]      countdown_nxt;
  logic [16:0]      diff;
  logic [33:0]      prod;
  logic             fire;

  assign fire = tick_valid && (countdown_r == '0);

  always_comb begin
    diff = {1'b0, period_r} - {9'b0, regs.ramp_step};
    if (diff[16] || (diff[15:0] < regs.min_period)) begin
      period_nxt = regs.min_period;
    end else begin
      period_nxt = diff[15:0];
    end
    prod = {18'b0, period_nxt} * {17'b0, RECIP10};
    phase_nxt = (phase_r == IDX_W'(TABLE_POINTS - 1)) ? '0 : phase_r + 1'b1;
    if (fire) begin
      countdown_nxt = prod[SHIFT10 +: 13];
    end else if (tick_valid) begin
      countdown_nxt = countdown_r - 13'd1;
    end else begin
      countdown_nxt = countdown_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      period_r    <= START_PERIOD_RESET;
      countdown_r <= '0;
      upd_valid_r <= 1'b0;
    end else if (start_load) begin
      period_r <= start_value;
    end else if (en) begin
      upd_valid_r <= fire;
      countdown_r <= countdown_nxt;
      if (fire) begin
        period_r <= period_nxt;
        phase_r  <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && fire) begin
      pos_r            <= phase_r;
      upd_r.period     <= period_nxt;
      upd_r.ramping    <= (period_nxt > regs.min_period);
      upd_r.wait_ticks <= prod[SHIFT10 +: 13];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/ssp_duty.sv
`default_nettype none
module ssp_duty #(
  parameter int TABLE_POINTS = 256,
  parameter int AMPLITUDE_OFFSET = 3,
  parameter int IDX_W = 8
) (
  input  wire logic [IDX_W-1:0]  pos,
  input  wire ssp_pkg::ssp_upd_t upd,
  output ssp_pkg::ssp_out_t      res
);
  import ssp_pkg::*;

  localparam int THIRD = TABLE_POINTS / 3;
  localparam int OFF_B = TABLE_POINTS - 2 * THIRD;
  localparam int OFF_C = TABLE_POINTS - THIRD;
  localparam int IW1 = IDX_W + 1;

  logic [7:0]     rom_w [TABLE_POINTS];
  logic [IDX_W:0] sum_b;
  logic [IDX_W:0] sum_c;
  logic [IDX_W:0] idx_b_w;
  logic [IDX_W:0] idx_c_w;
  logic [16:0]    biased;
  logic [33:0]    prod;
  logic [9:0]     cut;

  for (genvar k = 0; k < TABLE_POINTS; k++) begin : g_rom
    localparam longint unsigned TH =
      (64'd628 * 64'(k) * Q30_ONE) / (64'd100 * 64'(TABLE_POINTS));
    assign rom_w[k] = sine_entry(TH, AMPLITUDE_OFFSET);
  end

  always_comb begin
    sum_b = {1'b0, pos} + IW1'(OFF_B);
    sum_c = {1'b0, pos} + IW1'(OFF_C);
    idx_b_w = (sum_b >= IW1'(TABLE_POINTS)) ? sum_b - IW1'(TABLE_POINTS) : sum_b;
    idx_c_w = (sum_c >= IW1'(TABLE_POINTS)) ? sum_c - IW1'(TABLE_POINTS) : sum_c;
    biased = {1'b0, upd.period} + CEIL_BIAS100;
    prod = {17'b0, biased} * {17'b0, RECIP100};
    cut = upd.ramping ? prod[SHIFT100 +: 10] : 10'd0;
    res.duty_a        = sat_sub(rom_w[pos], cut);
    res.duty_b        = sat_sub(rom_w[idx_b_w[IDX_W-1:0]], cut);
    res.duty_c        = sat_sub(rom_w[idx_c_w[IDX_W-1:0]], cut);
    res.sine_position = 8'(pos);
    res.wait_ticks    = upd.wait_ticks;
    res.still_ramping = upd.ramping;
  end

endmodule
`default_nettype wire

>>> hw/rtl/three_phase_sine_pwm_softstart_unit.sv
`default_nettype none
// Three-phase sine duty generator with soft start. Each input request is one timer tick
// (tick_elapsed = 1) or a no-op (0). A tick that finds the step timer expired lowers the
// step period by the ramp step (floored at the minimum, in tenths of a tick), reloads the
// timer with period/10 and yields one result: three duties 120 degrees apart read from a
// sine table built at elaboration, each reduced by ceil(period/100) while still ramping.
// One request is taken every clock while in_req.ready is high; each accepted request passes
// the input register, state-update register and output register. in_req.ready falls
// only while a finished result waits at the output. The configuration port is always ready
// and should be written only while idle; writing the start period restarts the ramp.
module three_phase_sine_pwm_softstart_unit #(
  parameter int TABLE_POINTS = 256,
  parameter int AMPLITUDE_OFFSET = 3
) (
  input wire logic   clk,
  input wire logic   rst_n,
  ssp_stream_if.sink   in_req,
  ssp_stream_if.source out_res,
  ssp_stream_if.sink   cfg_wr
);
  import ssp_pkg::*;

  localparam int IDX_W = $clog2(TABLE_POINTS);

  logic              en;
  logic              in_valid_r;
  logic              tick_r;
  logic              cfg_fire;
  logic              start_load;
  ssp_regs_t         regs_r;
  logic              upd_valid_r;
  logic [IDX_W-1:0]  pos_r;
  ssp_upd_t          upd_r;
  ssp_out_t          res;
  logic              out_valid_r;
  ssp_out_t          out_data_r;

  assign en = !out_valid_r || out_res.ready;
  assign in_req.ready = en;
  assign cfg_wr.ready = 1'b1;
  assign cfg_fire = cfg_wr.valid;
  assign start_load = cfg_fire && (cfg_wr.payload.index == REG_START_PERIOD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.start_period <= START_PERIOD_RESET;
      regs_r.min_period   <= MIN_PERIOD_RESET;
      regs_r.ramp_step    <= RAMP_STEP_RESET;
    end else if (cfg_fire) begin
      case (cfg_wr.payload.index)
        REG_START_PERIOD: regs_r.start_period <= cfg_wr.payload.data;
        REG_MIN_PERIOD:   regs_r.min_period   <= cfg_wr.payload.data;
        REG_RAMP_STEP:    regs_r.ramp_step    <= cfg_wr.payload.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (en) begin
      in_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tick_r <= in_req.payload.tick_elapsed;
    end
  end

  ssp_step #(
    .TABLE_POINTS(TABLE_POINTS),
    .IDX_W(IDX_W)
  ) u_step (
    .clk(clk),
    .rst_n(rst_n),
    .en(en),
    .tick_valid(in_valid_r && tick_r),
    .regs(regs_r),
    .start_load(start_load),
    .start_value(cfg_wr.payload.data),
    .upd_valid_r(upd_valid_r),
    .pos_r(pos_r),
    .upd_r(upd_r)
  );

  ssp_duty #(
    .TABLE_POINTS(TABLE_POINTS),
    .AMPLITUDE_OFFSET(AMPLITUDE_OFFSET),
    .IDX_W(IDX_W)
  ) u_duty (
    .pos(pos_r),
    .upd(upd_r),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= upd_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && upd_valid_r) begin
      out_data_r <= res;
    end
  end

  assign out_res.valid   = out_valid_r;
  assign out_res.payload = out_data_r;

endmodule
`default_nettype wire

>>> sim/tb_three_phase_sine_pwm_softstart_unit.sv
`default_nettype none
module tb_three_phase_sine_pwm_softstart_unit;
  import ssp_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int TABLE_SIZE = 256;
  localparam int LAG_240 = TABLE_SIZE - 2 * (TABLE_SIZE / 3);
  localparam int LAG_120 = TABLE_SIZE - TABLE_SIZE / 3;
  localparam int SINE_GAIN = 126;
  localparam int DUTY_BASE = 3;
  localparam longint unsigned ONE_FIX = 64'd1073741824;
  localparam longint unsigned PI_FIX = 64'd3373259426;
  localparam longint unsigned HALF_PI_FIX = 64'd1686629713;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRINT_CAP = 100;

  logic clk = 1'b0;
  logic rst_n;

  ssp_stream_if #(.payload_t(ssp_in_t))  in_bus ();
  ssp_stream_if #(.payload_t(ssp_out_t)) out_bus ();
  ssp_stream_if #(.payload_t(ssp_cfg_t)) cfg_bus ();

  three_phase_sine_pwm_softstart_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(in_bus),
    .out_res(out_bus),
    .cfg_wr(cfg_bus)
  );

  logic [7:0]  sine_table [TABLE_SIZE];
  logic [15:0] start_reg;
  logic [15:0] floor_reg;
  logic [7:0]  step_reg;
  logic [15:0] ramp_period;
  logic [12:0] ticks_left;
  logic [7:0]  phase_pos;

  ssp_out_t pending_duties [$];

  int mismatches = 0;
  int requests_sent = 0;
  int updates_predicted = 0;
  int updates_checked = 0;
  int reg_writes = 0;
  int out_hold_cycles = 0;
  bit steady_flow = 1'b0;

  always #10 clk = ~clk;

  function automatic logic [7:0] sine_level(input longint unsigned k);
    longint unsigned ang;
    longint unsigned pw;
    longint unsigned acc_pos;
    longint unsigned acc_neg;
    longint unsigned mag;
    longint unsigned lvl;
    longint unsigned raw;
    bit lower;
    ang = (64'd628 * k * ONE_FIX) / (64'd100 * TABLE_SIZE);
    lower = 1'b0;
    if (ang >= PI_FIX) begin
      ang = ang - PI_FIX;
      lower = 1'b1;
    end
    if (ang > HALF_PI_FIX) begin
      ang = PI_FIX - ang;
    end
    pw = ang;
    acc_pos = ang;
    acc_neg = 0;
    for (int n = 1; n <= 8; n++) begin
      pw = (pw * ang) >> 30;
      pw = (pw * ang) >> 30;
      pw = pw / longint'(2 * n * (2 * n + 1));
      if (n % 2 == 1) begin
        acc_neg = acc_neg + pw;
      end else begin
        acc_pos = acc_pos + pw;
      end
    end
    mag = (acc_pos > acc_neg) ? acc_pos - acc_neg : 0;
    if (mag > ONE_FIX) begin
      mag = ONE_FIX;
    end
    lvl = lower ? ONE_FIX - mag : ONE_FIX + mag;
    raw = DUTY_BASE + ((lvl * SINE_GAIN) >> 30);
    return (raw > 255) ? 8'd255 : raw[7:0];
  endfunction

  function automatic logic [7:0] trimmed_duty(input int idx, input int cut);
    int v;
    v = sine_table[idx % TABLE_SIZE];
    return (v > cut) ? 8'(v - cut) : 8'd0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic predict_tick(input logic tick);
    ssp_out_t res;
    int period;
    int cut;
    if (!tick) return;
    if (ticks_left != 0) begin
      ticks_left = ticks_left - 13'd1;
      return;
    end
    period = ramp_period;
    if (period < step_reg || period - step_reg < floor_reg) begin
      period = floor_reg;
    end else begin
      period = period - step_reg;
    end
    ramp_period = 16'(period);
    res.still_ramping = (period > floor_reg);
    cut = res.still_ramping ? (period + 99) / 100 : 0;
    res.duty_a = trimmed_duty(phase_pos, cut);
    res.duty_b = trimmed_duty(phase_pos + LAG_240, cut);
    res.duty_c = trimmed_duty(phase_pos + LAG_120, cut);
    res.sine_position = phase_pos;
    ticks_left = 13'(period / 10);
    res.wait_ticks = ticks_left;
    phase_pos = phase_pos + 8'd1;
    pending_duties.push_back(res);
    updates_predicted++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_bus.payload <= '{index: idx, data: value};
    cfg_bus.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_START_PERIOD: begin
        start_reg = value;
        ramp_period = value;
      end
      REG_MIN_PERIOD: floor_reg = value;
      REG_RAMP_STEP: step_reg = value[7:0];
      default: ;
    endcase
    reg_writes++;
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_tick(input logic tick);
    int gap;
    gap = (!steady_flow && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.payload <= '{tick_elapsed: tick};
    in_bus.valid <= 1'b1;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    requests_sent++;
    predict_tick(tick);
  endtask

  task automatic send_pattern(input logic [31:0] bits, input int count);
    for (int i = 0; i < count; i++) begin
      send_tick(bits[i]);
    end
  endtask

  task automatic tick_until_update();
    int mark;
    mark = updates_predicted;
    while (updates_predicted == mark) send_tick(1'b1);
  endtask

  // drop valid, drain every expected result, then let in-flight ticks retire
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    steady_flow = 1'b0;
    write_reg(REG_NONE, 16'hFFFF);
    write_reg(REG_MIN_PERIOD, 16'd30);
    write_reg(REG_RAMP_STEP, 16'hA507);
    write_reg(REG_START_PERIOD, 16'd50);
    send_pattern(32'b1111_1011_1110, 12);
    settle();
    write_reg(REG_RAMP_STEP, 16'd255);
    write_reg(REG_START_PERIOD, 16'd200);
    send_pattern(32'b1111, 4);
    settle();
    write_reg(REG_MIN_PERIOD, 16'd120);
    send_pattern(32'b1111, 4);
  endtask

  task automatic test_output_stall();
    settle();
    write_reg(REG_MIN_PERIOD, 16'd0);
    write_reg(REG_START_PERIOD, 16'd0);
    steady_flow = 1'b1;
    out_hold_cycles = 200;
    repeat (60) send_tick(1'b1);
    settle();
    repeat (30) send_tick(1'b1);
  endtask

  task automatic test_random_ramps();
    int first_period;
    int floor_val;
    int step_val;
    for (int phase = 0; phase < 12; phase++) begin
      settle();
      case ($urandom_range(0, 3))
        0: begin
          first_period = 0;
          floor_val = 0;
        end
        1: begin
          first_period = $urandom_range(100, 2000);
          floor_val = $urandom_range(0, first_period);
        end
        2: begin
          first_period = $urandom_range(0, 400);
          floor_val = first_period + $urandom_range(1, 300);
        end
        default: begin
          first_period = $urandom_range(0, 1200);
          floor_val = $urandom_range(0, 300);
        end
      endcase
      step_val = $urandom_range(0, 1) ? $urandom_range(0, 20) : $urandom_range(0, 255);
      write_reg(REG_MIN_PERIOD, 16'(floor_val));
      write_reg(REG_RAMP_STEP, {8'($urandom), 8'(step_val)});
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_START_PERIOD, 16'(first_period));
      end
      steady_flow = (phase >= 9) || ($urandom_range(0, 3) == 0);
      repeat (135) send_tick($urandom_range(0, 9) != 0);
    end
  endtask

  task automatic test_extreme_periods();
    steady_flow = 1'b1;
    settle();
    write_reg(REG_MIN_PERIOD, 16'd0);
    write_reg(REG_RAMP_STEP, 16'd0);
    write_reg(REG_START_PERIOD, 16'hFFFF);
    tick_until_update();
  endtask

  task automatic finish_run();
    int waited;
    in_bus.valid <= 1'b0;
    waited = 0;
    while (pending_duties.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_duties.size() != 0) begin
      report_mismatch("undelivered results", 0, pending_duties.size());
    end
    $display("%0d tick requests and %0d register writes over ramp, floor, stall and extreme periods",
             requests_sent, reg_writes);
    $display("%0d duty updates checked, %0d mismatches", updates_checked, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  endtask

  always @(posedge clk) begin : result_check
    ssp_out_t got;
    ssp_out_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = out_bus.payload;
      if (pending_duties.size() == 0) begin
        report_mismatch("result with nothing expected, sine_position", got.sine_position, -1);
      end else begin
        want = pending_duties.pop_front();
        updates_checked++;
        if (got.duty_a !== want.duty_a)
          report_mismatch("duty_a", got.duty_a, want.duty_a);
        if (got.duty_b !== want.duty_b)
          report_mismatch("duty_b", got.duty_b, want.duty_b);
        if (got.duty_c !== want.duty_c)
          report_mismatch("duty_c", got.duty_c, want.duty_c);
        if (got.sine_position !== want.sine_position)
          report_mismatch("sine_position", got.sine_position, want.sine_position);
        if (got.wait_ticks !== want.wait_ticks)
          report_mismatch("wait_ticks", got.wait_ticks, want.wait_ticks);
        if (got.still_ramping !== want.still_ramping)
          report_mismatch("still_ramping", got.still_ramping, want.still_ramping);
      end
    end
  end

  initial begin : result_sink
    int n;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_hold_cycles > 0) begin
        n = out_hold_cycles;
        out_hold_cycles = 0;
        out_bus.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!steady_flow && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #(64'd50_000_000);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.payload <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.payload <= '0;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      sine_table[k] = sine_level(k);
    end
    start_reg = START_PERIOD_RESET;
    floor_reg = MIN_PERIOD_RESET;
    step_reg = RAMP_STEP_RESET;
    ramp_period = START_PERIOD_RESET;
    ticks_left = '0;
    phase_pos = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_output_stall();
    test_random_ramps();
    test_extreme_periods();
    finish_run();
  end

endmodule
`default_nettype wire
